// ----- sv/cqp_pkg.sv -----
`default_nettype none
package cqp_pkg;

  localparam int QUEUE_DEPTH = 1024;
  localparam int IDX_W       = 10;
  localparam int SIZE_W      = 11;
  localparam int CNT_W       = 16;
  localparam int THR_W       = 8;
  localparam int TIME_W      = 16;
  localparam int HEAD_W      = 16;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(QUEUE_DEPTH);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  localparam logic RES_OK      = 1'b0;
  localparam logic RES_INVALID = 1'b1;

  typedef enum logic [1:0] {
    REQ_POST = 2'd0,
    REQ_HEAD = 2'd1,
    REQ_TICK = 2'd2,
    REQ_POLL = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    REG_QEN  = 3'd0,
    REG_IEN  = 3'd1,
    REG_SIZE = 3'd2,
    REG_THR  = 3'd3,
    REG_TIME = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic              qen;
    logic              ien;
    logic [SIZE_W-1:0] size;
    logic [THR_W-1:0]  thr;
    logic [TIME_W-1:0] tmo;
    logic              init;
  } cfg_t;

  typedef struct packed {
    logic load;
    req_t op;
  } dp_cmd_t;

endpackage
`default_nettype wire

// ----- sv/completion_queue_poster.sv -----
// timing: a result word appears in the cycle after its request word is accepted
// throughput: one word per cycle while results are taken; the output register
//   holds a stalled result and the input stalls only while that result is stalled
// reset: pointers 0, phase 1, pending 0, elapsed ticks saturated, registers at
//   their reset values; no clearing pass, words are taken right after reset
`default_nettype none
module completion_queue_poster (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [cqp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cqp_pkg::DATA_W-1:0] pwdata,
  output logic      [cqp_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_req_type,
  input  wire logic [31:0]               in_cmd_specific,
  input  wire logic [31:0]               in_reserved_word,
  input  wire logic [15:0]               in_sq_head_ptr,
  input  wire logic [15:0]               in_sq_ident,
  input  wire logic [15:0]               in_command_id,
  input  wire logic [15:0]               in_status_field,
  input  wire logic [15:0]               in_doorbell_head,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_result_code,
  output logic                           out_entry_write,
  output logic      [9:0]                out_slot_index,
  output logic      [31:0]               out_cmd_specific,
  output logic      [31:0]               out_reserved,
  output logic      [15:0]               out_sq_head,
  output logic      [15:0]               out_sq_ident,
  output logic      [15:0]               out_command_id,
  output logic      [15:0]               out_status,
  output logic                           out_interrupt_fire
);
  import cqp_pkg::*;

  cfg_t    cfg;
  dp_cmd_t dp_cmd;

  cqp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cqp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .out_stall   (out_stall),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .dp_cmd      (dp_cmd)
  );

  cqp_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .dp_cmd             (dp_cmd),
    .in_cmd_specific    (in_cmd_specific),
    .in_reserved_word   (in_reserved_word),
    .in_sq_head_ptr     (in_sq_head_ptr),
    .in_sq_ident        (in_sq_ident),
    .in_command_id      (in_command_id),
    .in_status_field    (in_status_field),
    .in_doorbell_head   (in_doorbell_head),
    .out_result_code    (out_result_code),
    .out_entry_write    (out_entry_write),
    .out_slot_index     (out_slot_index),
    .out_cmd_specific   (out_cmd_specific),
    .out_reserved       (out_reserved),
    .out_sq_head        (out_sq_head),
    .out_sq_ident       (out_sq_ident),
    .out_command_id     (out_command_id),
    .out_status         (out_status),
    .out_interrupt_fire (out_interrupt_fire)
  );

endmodule
`default_nettype wire

// ----- sv/cqp_regs.sv -----
`default_nettype none
module cqp_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [cqp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cqp_pkg::DATA_W-1:0] pwdata,
  output logic      [cqp_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  output cqp_pkg::cfg_t                  cfg
);
  import cqp_pkg::*;

  logic              qen_r;
  logic              ien_r;
  logic [SIZE_W-1:0] size_r;
  logic [THR_W-1:0]  thr_r;
  logic [TIME_W-1:0] tmo_r;
  logic              qen_rise;
  logic              wr;
  reg_idx_t          idx;

  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite;
  assign idx      = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign qen_rise = wr && (idx == REG_QEN) && pwdata[0] && !qen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qen_r  <= 1'b0;
      ien_r  <= 1'b0;
      size_r <= SIZE_RESET;
      thr_r  <= '0;
      tmo_r  <= '0;
    end else begin
      if (wr) begin
        unique case (idx)
          REG_QEN:  qen_r  <= pwdata[0];
          REG_IEN:  ien_r  <= pwdata[0];
          REG_SIZE: size_r <= pwdata[SIZE_W-1:0];
          REG_THR:  thr_r  <= pwdata[THR_W-1:0];
          REG_TIME: tmo_r  <= pwdata[TIME_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_QEN:  prdata = DATA_W'(qen_r);
      REG_IEN:  prdata = DATA_W'(ien_r);
      REG_SIZE: prdata = DATA_W'(size_r);
      REG_THR:  prdata = DATA_W'(thr_r);
      REG_TIME: prdata = DATA_W'(tmo_r);
      default:  prdata = '0;
    endcase
  end

  // init clears the queue at the same edge as the enabling write
  assign cfg = '{qen: qen_r, ien: ien_r, size: size_r, thr: thr_r, tmo: tmo_r,
                 init: qen_rise};

endmodule
`default_nettype wire

// ----- sv/cqp_ctrl.sv -----
`default_nettype none
module cqp_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_req_type,
  input  wire logic       out_stall,
  output logic            in_stall,
  output logic            out_valid,
  output cqp_pkg::dp_cmd_t dp_cmd
);
  import cqp_pkg::*;

  typedef enum logic {
    S_EMPTY,
    S_FULL
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall  = (state_r == S_FULL) && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state_r == S_FULL);
  assign dp_cmd    = '{load: accept, op: req_t'(in_req_type)};

  always_comb begin
    state_nxt = state_r;
    priority if (accept) begin
      state_nxt = S_FULL;
    end else if (!out_stall) begin
      state_nxt = S_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/cqp_dpath.sv -----
`default_nettype none
module cqp_dpath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire cqp_pkg::cfg_t             cfg,
  input  wire cqp_pkg::dp_cmd_t          dp_cmd,
  input  wire logic [31:0]               in_cmd_specific,
  input  wire logic [31:0]               in_reserved_word,
  input  wire logic [15:0]               in_sq_head_ptr,
  input  wire logic [15:0]               in_sq_ident,
  input  wire logic [15:0]               in_command_id,
  input  wire logic [15:0]               in_status_field,
  input  wire logic [cqp_pkg::HEAD_W-1:0] in_doorbell_head,
  output logic                           out_result_code,
  output logic                           out_entry_write,
  output logic      [cqp_pkg::IDX_W-1:0]  out_slot_index,
  output logic      [31:0]               out_cmd_specific,
  output logic      [31:0]               out_reserved,
  output logic      [15:0]               out_sq_head,
  output logic      [15:0]               out_sq_ident,
  output logic      [15:0]               out_command_id,
  output logic      [15:0]               out_status,
  output logic                           out_interrupt_fire
);
  import cqp_pkg::*;

  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic              phase_r, phase_nxt;
  logic [CNT_W-1:0]  pend_r, pend_nxt;
  logic [CNT_W-1:0]  elap_r, elap_nxt;

  logic              code_nxt;
  logic              ewr_nxt;
  logic              fire_nxt;
  logic [SIZE_W-1:0] eff_size;
  logic [SIZE_W-1:0] tail_inc;
  logic              wrap;
  logic              head_bad;
  logic              fire;

  always_comb begin
    eff_size = cfg.size;
    if (cfg.size < SIZE_MIN) eff_size = SIZE_MIN;
    if (cfg.size > SIZE_MAX) eff_size = SIZE_MAX;
  end

  assign tail_inc = SIZE_W'(tail_r) + SIZE_W'(1);
  assign wrap     = tail_inc >= eff_size;
  assign head_bad = in_doorbell_head >= HEAD_W'(eff_size);

  always_comb begin
    fire = cfg.ien && (head_r != tail_r);
    if ((cfg.thr != '0) && (pend_r < CNT_W'(cfg.thr))) fire = 1'b0;
    if ((cfg.tmo != '0) && (elap_r < cfg.tmo)) fire = 1'b0;
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    elap_nxt  = elap_r;
    code_nxt  = RES_OK;
    ewr_nxt   = 1'b0;
    fire_nxt  = 1'b0;
    if (dp_cmd.op == REQ_TICK) begin
      if (elap_r != '1) elap_nxt = elap_r + CNT_W'(1);
    end else if (!cfg.qen) begin
      code_nxt = RES_INVALID;
    end else begin
      unique case (dp_cmd.op)
        REQ_POST: begin
          ewr_nxt = 1'b1;
          if (wrap) begin
            tail_nxt  = '0;
            phase_nxt = !phase_r;
          end else begin
            tail_nxt = tail_inc[IDX_W-1:0];
          end
          if (cfg.ien && (pend_r != '1)) pend_nxt = pend_r + CNT_W'(1);
        end
        REQ_HEAD: begin
          if (head_bad) code_nxt = RES_INVALID;
          else head_nxt = in_doorbell_head[IDX_W-1:0];
        end
        REQ_POLL: begin
          if (fire) begin
            fire_nxt = 1'b1;
            pend_nxt = '0;
            elap_nxt = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg.init) begin
      head_r  <= '0;
      tail_r  <= '0;
      phase_r <= 1'b1;
      pend_r  <= '0;
      elap_r  <= '1;
    end else if (dp_cmd.load) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      elap_r  <= elap_nxt;
    end
  end

  // output word, zeroed entry fields unless a post was stored
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      out_result_code    <= code_nxt;
      out_entry_write    <= ewr_nxt;
      out_interrupt_fire <= fire_nxt;
      out_slot_index     <= ewr_nxt ? tail_r : '0;
      out_cmd_specific   <= ewr_nxt ? in_cmd_specific : '0;
      out_reserved       <= ewr_nxt ? in_reserved_word : '0;
      out_sq_head        <= ewr_nxt ? in_sq_head_ptr : '0;
      out_sq_ident       <= ewr_nxt ? in_sq_ident : '0;
      out_command_id     <= ewr_nxt ? in_command_id : '0;
      out_status         <= ewr_nxt ? {in_status_field[15:1], phase_r} : '0;
    end
  end

endmodule
`default_nettype wire

// ----- sv/cqp_checker.sv -----
`default_nettype none
module cqp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_result_code,
  input wire logic        out_entry_write,
  input wire logic [9:0]  out_slot_index,
  input wire logic        out_interrupt_fire
);

  a_held_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result word dropped");

  a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted word produced no result");

  a_post_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_write |-> !out_result_code && !out_interrupt_fire)
    else $error("stored entry flagged invalid or firing");

  a_fire_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_interrupt_fire |-> !out_result_code && out_slot_index == 10'd0)
    else $error("interrupt result carries entry data or error");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind completion_queue_poster cqp_checker u_cqp_checker (.*);
`default_nettype wire
